@@ rtl/matrix_inverse_3x3_macros.svh @@
// Assertion helpers used by the RTL that checks itself.
`ifndef MATRIX_INVERSE_3X3_MACROS_SVH
`define MATRIX_INVERSE_3X3_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define MI3_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked a fixed number of cycles later.
`define MI3_ASSERT_AFTER(lbl, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

@@ rtl/mi3_pkg.sv @@
`default_nettype none

package mi3_pkg;

  localparam int IN_W      = 16;
  localparam int OUT_W     = 32;
  localparam int COF_W     = 32;
  localparam int PROD_W    = 48;
  localparam int EXACT_W   = 50;
  localparam int DET_W     = 48;
  localparam int REG_W     = 47;
  localparam int NUM_W     = 48;
  localparam int FRAC_SH   = 16;
  localparam int Q_W       = 33;
  localparam int DIV_STEPS = 33;
  localparam int LANES     = 9;
  localparam int ROUND_SH  = 12;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_DET_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DET_SUBSTITUTE = 2'd1;

  localparam logic [REG_W-1:0] THRESHOLD_RESET  = 47'd2;
  localparam logic [REG_W-1:0] SUBSTITUTE_RESET = 47'd168;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam logic [OUT_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [OUT_W-1:0] SAT_NEG = 32'h8000_0000;

  typedef struct packed {
    logic signed [IN_W-1:0] m00;
    logic signed [IN_W-1:0] m01;
    logic signed [IN_W-1:0] m02;
    logic signed [IN_W-1:0] m10;
    logic signed [IN_W-1:0] m11;
    logic signed [IN_W-1:0] m12;
    logic signed [IN_W-1:0] m20;
    logic signed [IN_W-1:0] m21;
    logic signed [IN_W-1:0] m22;
  } mat_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] r00;
    logic signed [OUT_W-1:0] r01;
    logic signed [OUT_W-1:0] r02;
    logic signed [OUT_W-1:0] r10;
    logic signed [OUT_W-1:0] r11;
    logic signed [OUT_W-1:0] r12;
    logic signed [OUT_W-1:0] r20;
    logic signed [OUT_W-1:0] r21;
    logic signed [OUT_W-1:0] r22;
    logic signed [DET_W-1:0] det_value;
    logic                    det_clamped;
  } res_t;

  // One classified matrix waiting for the dividers.
  typedef struct packed {
    logic [LANES-1:0][COF_W-1:0] cof;
    logic signed [DET_W-1:0]     det;
    logic                        clamped;
  } job_t;

endpackage

`default_nettype wire

@@ rtl/mi3_front.sv @@
`default_nettype none

module mi3_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        accept,
  input  wire mi3_pkg::mat_t               mat,
  input  wire logic [mi3_pkg::REG_W-1:0]   det_threshold,
  input  wire logic [mi3_pkg::REG_W-1:0]   det_substitute,
  output logic                             push,
  output mi3_pkg::job_t                    job,
  output logic [1:0]                       inflight
);

  logic v1, v2, v3;
  logic signed [mi3_pkg::IN_W-1:0]  a [mi3_pkg::LANES];
  logic signed [mi3_pkg::COF_W-1:0] c_next [mi3_pkg::LANES];
  logic signed [mi3_pkg::COF_W-1:0] cof2 [mi3_pkg::LANES];
  logic signed [mi3_pkg::COF_W-1:0] cof3 [mi3_pkg::LANES];
  logic signed [mi3_pkg::IN_W-1:0]  a0, a3, a6;
  logic signed [mi3_pkg::PROD_W-1:0] p0, p1, p2;
  logic signed [mi3_pkg::EXACT_W-1:0] exact, rounded;
  logic signed [mi3_pkg::DET_W-1:0] det_raw;
  logic [mi3_pkg::DET_W-1:0] mag;
  logic clamp;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a[0] <= mat.m00; a[1] <= mat.m01; a[2] <= mat.m02;
      a[3] <= mat.m10; a[4] <= mat.m11; a[5] <= mat.m12;
      a[6] <= mat.m20; a[7] <= mat.m21; a[8] <= mat.m22;
    end
  end

  // Cofactors, laid out as the adjugate (the transposed cofactor matrix)
  always_comb begin
    c_next[0] = a[4] * a[8] - a[7] * a[5];
    c_next[1] = a[7] * a[2] - a[1] * a[8];
    c_next[2] = a[1] * a[5] - a[4] * a[2];
    c_next[3] = a[5] * a[6] - a[3] * a[8];
    c_next[4] = a[0] * a[8] - a[2] * a[6];
    c_next[5] = a[2] * a[3] - a[0] * a[5];
    c_next[6] = a[3] * a[7] - a[4] * a[6];
    c_next[7] = a[1] * a[6] - a[0] * a[7];
    c_next[8] = a[0] * a[4] - a[1] * a[3];
  end

  always_ff @(posedge clk) begin
    cof2 <= c_next;
    a0   <= a[0];
    a3   <= a[3];
    a6   <= a[6];
    cof3 <= cof2;
    p0   <= a0 * cof2[0];
    p1   <= a3 * cof2[1];
    p2   <= a6 * cof2[2];
  end

  // Round half up to Q24.24, then test against the singular threshold and substitute
  always_comb begin
    exact   = p0 + p1 + p2;
    rounded = (exact + mi3_pkg::EXACT_W'(2048)) >>> mi3_pkg::ROUND_SH;
    det_raw = rounded[mi3_pkg::DET_W-1:0];
    mag     = det_raw[mi3_pkg::DET_W-1] ? -det_raw : det_raw;
    clamp   = mag < {1'b0, det_threshold};
    for (int i = 0; i < mi3_pkg::LANES; i++) begin
      job.cof[i] = cof3[i];
    end
    job.det     = clamp ? $signed({1'b0, det_substitute}) : det_raw;
    job.clamped = clamp;
  end

  assign push     = v3;
  assign inflight = 2'({1'b0, v1} + {1'b0, v2} + {1'b0, v3});

endmodule

`default_nettype wire

@@ rtl/mi3_queue.sv @@
`default_nettype none

module mi3_queue (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  input  wire mi3_pkg::job_t               wdata,
  input  wire logic                        pop,
  output mi3_pkg::job_t                    rdata,
  output logic                             empty,
  output logic                             full,
  output logic [mi3_pkg::QCNT_W-1:0]       count
);

  mi3_pkg::job_t mem [mi3_pkg::QDEPTH];
  logic [mi3_pkg::QPTR_W-1:0] wp, rp;
  logic do_push, do_pop;

  assign empty   = (count == '0);
  assign full    = (count == mi3_pkg::QCNT_W'(mi3_pkg::QDEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_push) wp <= wp + 1'b1;
      if (do_pop) rp <= rp + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wp] <= wdata;
  end

endmodule

`default_nettype wire

@@ rtl/mi3_back.sv @@
`default_nettype none

module mi3_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          take,
  input  wire mi3_pkg::job_t job,
  output logic               done,
  output mi3_pkg::res_t      res
);

  typedef struct packed {
    logic                          neg;
    logic                          cpos;
    logic                          cneg;
    logic                          ovf;
    logic [mi3_pkg::NUM_W-1:0]     rem;
    logic [mi3_pkg::NUM_W-1:0]     num;
    logic [mi3_pkg::Q_W-1:0]       q;
  } lane_t;

  typedef struct packed {
    lane_t [mi3_pkg::LANES-1:0]     lane;
    logic [mi3_pkg::DET_W-1:0]      den;
    logic                           dz;
    logic signed [mi3_pkg::DET_W-1:0] det;
    logic                           clamped;
  } stage_t;

  stage_t stg [mi3_pkg::DIV_STEPS+1];
  logic   vld [mi3_pkg::DIV_STEPS+1];
  stage_t first;
  logic [mi3_pkg::OUT_W-1:0] r [mi3_pkg::LANES];

  // Set up signs, magnitudes and the overflow test for every lane
  always_comb begin
    logic signed [mi3_pkg::COF_W-1:0] cof;
    logic [mi3_pkg::COF_W-1:0]        cmag;
    first.det     = job.det;
    first.clamped = job.clamped;
    first.den     = job.det[mi3_pkg::DET_W-1] ? -job.det : job.det;
    first.dz      = (job.det == '0);
    for (int l = 0; l < mi3_pkg::LANES; l++) begin
      cof  = $signed(job.cof[l]);
      cmag = cof[mi3_pkg::COF_W-1] ? -cof : cof;
      first.lane[l].neg  = cof[mi3_pkg::COF_W-1] != job.det[mi3_pkg::DET_W-1];
      first.lane[l].cpos = !cof[mi3_pkg::COF_W-1] && (cof != '0);
      first.lane[l].cneg = cof[mi3_pkg::COF_W-1];
      first.lane[l].num  = {cmag, {mi3_pkg::FRAC_SH{1'b0}}};
      first.lane[l].rem  = mi3_pkg::NUM_W'(first.lane[l].num[mi3_pkg::NUM_W-1:mi3_pkg::Q_W]);
      first.lane[l].ovf  = first.lane[l].rem >= first.den;
      first.lane[l].q    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else vld[0] <= take;
  end

  always_ff @(posedge clk) begin
    stg[0] <= first;
  end

  // One quotient bit per stage, all nine lanes side by side
  for (genvar s = 0; s < mi3_pkg::DIV_STEPS; s++) begin : g_div
    localparam int K = mi3_pkg::DIV_STEPS - 1 - s;
    stage_t nxt;

    always_comb begin
      logic [mi3_pkg::NUM_W:0] rs;
      nxt = stg[s];
      for (int l = 0; l < mi3_pkg::LANES; l++) begin
        rs = {stg[s].lane[l].rem, stg[s].lane[l].num[K]};
        if (rs >= {1'b0, stg[s].den}) begin
          rs = rs - {1'b0, stg[s].den};
          nxt.lane[l].q[K] = 1'b1;
        end
        nxt.lane[l].rem = rs[mi3_pkg::NUM_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) vld[s+1] <= 1'b0;
      else vld[s+1] <= vld[s];
    end

    always_ff @(posedge clk) begin
      stg[s+1] <= nxt;
    end
  end

  // Apply sign and saturate to Q16.16; on a zero determinant, saturate by cofactor sign
  always_comb begin
    lane_t ln;
    logic  big;
    for (int l = 0; l < mi3_pkg::LANES; l++) begin
      ln  = stg[mi3_pkg::DIV_STEPS].lane[l];
      big = ln.ovf || (ln.q[mi3_pkg::Q_W-1:mi3_pkg::OUT_W-1] != '0);
      if (stg[mi3_pkg::DIV_STEPS].dz) begin
        r[l] = ln.cpos ? mi3_pkg::SAT_POS : (ln.cneg ? mi3_pkg::SAT_NEG : '0);
      end else if (ln.neg) begin
        r[l] = big ? mi3_pkg::SAT_NEG : -ln.q[mi3_pkg::OUT_W-1:0];
      end else begin
        r[l] = big ? mi3_pkg::SAT_POS : ln.q[mi3_pkg::OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= vld[mi3_pkg::DIV_STEPS];
  end

  always_ff @(posedge clk) begin
    res.r00         <= r[0];
    res.r01         <= r[1];
    res.r02         <= r[2];
    res.r10         <= r[3];
    res.r11         <= r[4];
    res.r12         <= r[5];
    res.r20         <= r[6];
    res.r21         <= r[7];
    res.r22         <= r[8];
    res.det_value   <= stg[mi3_pkg::DIV_STEPS].det;
    res.det_clamped <= stg[mi3_pkg::DIV_STEPS].clamped;
  end

endmodule

`default_nettype wire

@@ rtl/matrix_inverse_3x3.sv @@
// 3x3 matrix inverse by the adjugate, Q4.12 in, Q16.16 out.
// Input: drive a matrix on mat and raise start; the transfer happens at a
// rising edge with start high and busy low. busy only rises if the job
// queue could overflow, which a steady stream never reaches, so a new
// matrix can be taken every cycle.
// Output: done is high for exactly one cycle with the result on res; the
// receiver cannot stall, so take the result in that cycle or lose it.
// Path: the start transfer reaches done through a front end of three stages,
// one queue slot, a setup register, 33 divider stages and an output register.
// Throughput: one matrix per cycle while busy is low; the nine pipelined
// restoring dividers, one quotient bit per stage, set the depth.
// Singular test: a determinant whose magnitude is below det_threshold is
// replaced by det_substitute and det_clamped is set.
// Configuration: write cfg_data to register cfg_index with cfg_we while no
// matrix is in flight; index 0 is the threshold, 1 the substitute, others
// are dropped.
// Reset: rst (synchronous) empties the pipe and the queue and restores the
// threshold to 2 and the substitute to 168.
`default_nettype none
`include "matrix_inverse_3x3_macros.svh"

module matrix_inverse_3x3 (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire mi3_pkg::mat_t                     mat,
  output logic                                   done,
  output mi3_pkg::res_t                          res,
  input  wire logic                              cfg_we,
  input  wire logic [mi3_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mi3_pkg::REG_W-1:0]         cfg_data
);

  logic [mi3_pkg::REG_W-1:0] det_threshold;
  logic [mi3_pkg::REG_W-1:0] det_substitute;
  logic                      accept;
  logic                      q_push;
  mi3_pkg::job_t             q_wdata;
  mi3_pkg::job_t             q_rdata;
  logic                      q_empty;
  logic                      q_full;
  logic [mi3_pkg::QCNT_W-1:0] q_count;
  logic [1:0]                inflight;

  // Configuration registers; hold value unless written
  always_ff @(posedge clk) begin
    if (rst) begin
      det_threshold  <= mi3_pkg::THRESHOLD_RESET;
      det_substitute <= mi3_pkg::SUBSTITUTE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mi3_pkg::REG_DET_THRESHOLD:  det_threshold  <= cfg_data;
        mi3_pkg::REG_DET_SUBSTITUTE: det_substitute <= cfg_data;
        default: ;
      endcase
    end
  end

  // Refuse a transfer when queued plus in-flight jobs could overflow the queue
  assign busy   = ({1'b0, q_count} + {2'b00, inflight}) >
                  (mi3_pkg::QCNT_W + 1)'(mi3_pkg::QDEPTH);
  assign accept = start && !busy;

  mi3_front u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .mat            (mat),
    .det_threshold  (det_threshold),
    .det_substitute (det_substitute),
    .push           (q_push),
    .job            (q_wdata),
    .inflight       (inflight)
  );

  // Back end drains the queue every cycle it holds a job
  mi3_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (!q_empty),
    .rdata (q_rdata),
    .empty (q_empty),
    .full  (q_full),
    .count (q_count)
  );

  mi3_back u_back (
    .clk  (clk),
    .rst  (rst),
    .take (!q_empty),
    .job  (q_rdata),
    .done (done),
    .res  (res)
  );

  `MI3_ASSERT_IMPLIES(a_no_overflow, q_push, !q_full, "job queue overflow")
  `MI3_ASSERT_IMPLIES(a_clamp_value, done && res.det_clamped, res.det_value == $signed({1'b0, det_substitute}), "clamped determinant differs from substitute")
  `MI3_ASSERT_AFTER(a_latency, accept, 39, done, "result missing after fixed latency")

endmodule

`default_nettype wire
